// ===== hw/rtl/cotd_pkg.sv =====
`default_nettype none

package cotd_pkg;

  // Default sizes of the cosine/sine tables and of the decimation ratio.
  localparam int unsigned TABLE_SIZE_DEF = 512;
  localparam int unsigned DECIMATION_DEF = 4;

  // Field and datapath widths.
  localparam int FREQ_W   = 24;  // signed Q15.8 input
  localparam int SCALE_W  = 32;  // unsigned Q0.32 scale register
  localparam int NORM_W   = 24;  // normalized frequency, Q0.24
  localparam int FRAC_W   = 24;  // interpolation fraction, Q0.24
  localparam int ROM_W    = 17;  // table entry, unsigned Q1.16
  localparam int INTERP_W = 41;  // interpolant, Q1.40
  localparam int COT_W    = 31;  // result, unsigned Q13.18
  localparam int COT_FRAC = 18;  // fraction bits of the result

  // Serial multiply steps: one magnitude bit of the frequency per cycle.
  localparam int MUL_STEPS = FREQ_W - 1;
  localparam int MUL_CNT_W = $clog2(MUL_STEPS);

  // Serial divide steps: one quotient bit per cycle.
  localparam int DIV_CNT_W = $clog2(COT_W);

  localparam logic [SCALE_W-1:0] FREQ_SCALE_RST = 32'd178957;

  // Clamp bounds of the normalized frequency, 0.0001 and 0.9 in Q0.24.
  localparam logic [NORM_W-1:0] NORM_MIN = 24'd1678;
  localparam logic [NORM_W-1:0] NORM_MAX = 24'd15099494;

  localparam logic [COT_W-1:0] COT_MAX = {COT_W{1'b1}};

  // Table build constants: pi/2 in Q2.30 and the Taylor series length.
  localparam logic [63:0] HALF_PI_Q30  = 64'd1686629713;
  localparam int          SERIES_TERMS = 10;

  // Term divisors of the sine and cosine series, (2k)(2k+1) and (2k-1)(2k).
  localparam logic [63:0] SIN_DIV [1:10] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
    64'd156, 64'd210, 64'd272, 64'd342, 64'd420
  };
  localparam logic [63:0] COS_DIV [1:10] = '{
    64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
    64'd132, 64'd182, 64'd240, 64'd306, 64'd380
  };

  // Status of the serial divider as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cotd_rom.sv =====
`default_nettype none

module cotd_rom #(
  parameter int unsigned TABLE_SIZE = cotd_pkg::TABLE_SIZE_DEF,
  parameter int          ADDR_W     = $clog2(TABLE_SIZE + 1)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rd_en_i,
  input  wire logic [ADDR_W-1:0]             addr_i,
  output logic      [cotd_pkg::ROM_W-1:0]    cos_o,
  output logic      [cotd_pkg::ROM_W-1:0]    sin_o
);

  localparam int EW = 2 * cotd_pkg::ROM_W;

  // Round a Q2.30 sum half up to Q1.16, clamped to 0 .. 1.0.
  function automatic logic [cotd_pkg::ROM_W-1:0] q30_to_q16(longint acc);
    logic [63:0] v;
    if (acc < 0) begin
      v = 64'd0;
    end else begin
      v = (64'(acc) + 64'd8192) >> 14;
    end
    if (v > 64'd65536) begin
      v = 64'd65536;
    end
    return v[cotd_pkg::ROM_W-1:0];
  endfunction

  // Quarter-wave table, entry i = {cos, sin} of i*pi/(2*TABLE_SIZE).
  function automatic logic [TABLE_SIZE:0][EW-1:0] build_rom();
    logic [TABLE_SIZE:0][EW-1:0] rom;
    logic [63:0]                 a;
    logic [63:0]                 a2;
    logic [63:0]                 ts;
    logic [63:0]                 tc;
    longint                      sacc;
    longint                      cacc;
    for (int i = 0; i <= int'(TABLE_SIZE); i++) begin
      a    = (64'(i) * cotd_pkg::HALF_PI_Q30) / 64'(TABLE_SIZE);
      a2   = (a * a) >> 30;
      ts   = a;
      tc   = 64'd1 << 30;
      sacc = longint'(a);
      cacc = longint'(64'd1 << 30);
      for (int k = 1; k <= cotd_pkg::SERIES_TERMS; k++) begin
        ts = ((ts * a2) >> 30) / cotd_pkg::SIN_DIV[k];
        tc = ((tc * a2) >> 30) / cotd_pkg::COS_DIV[k];
        if ((k % 2) == 1) begin
          sacc = sacc - longint'(ts);
          cacc = cacc - longint'(tc);
        end else begin
          sacc = sacc + longint'(ts);
          cacc = cacc + longint'(tc);
        end
      end
      rom[i] = {q30_to_q16(cacc), q30_to_q16(sacc)};
    end
    return rom;
  endfunction

  localparam logic [TABLE_SIZE:0][EW-1:0] ROM = build_rom();

  logic [EW-1:0] rd_q;

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= ROM[addr_i];
    end
  end

  assign cos_o = rd_q[EW-1:cotd_pkg::ROM_W];
  assign sin_o = rd_q[cotd_pkg::ROM_W-1:0];

endmodule

`default_nettype wire

// ===== hw/rtl/cotd_div.sv =====
`default_nettype none

module cotd_div (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  input  wire logic [cotd_pkg::INTERP_W-1:0]    dividend_i,
  input  wire logic [cotd_pkg::INTERP_W-1:0]    divisor_i,
  output cotd_pkg::div_stat_t                   stat_o,
  output logic      [cotd_pkg::COT_W-1:0]       quot_o
);

  localparam int IW    = cotd_pkg::INTERP_W;
  localparam int QW    = cotd_pkg::COT_W;
  localparam int QF    = cotd_pkg::COT_FRAC;
  localparam int HI_SH = QW - QF;  // low dividend bits shifted in behind the remainder

  logic [IW-1:0]                    rem_q;
  logic [IW-1:0]                    dvs_q;
  logic [QW-1:0]                    dsr_q;
  logic [QW-1:0]                    quo_q;
  logic                             ovf_q;
  logic [cotd_pkg::DIV_CNT_W-1:0]   cnt_q;
  logic                             busy_q;
  logic                             done_q;

  logic [IW:0]   trial;
  logic          ge;
  logic [IW-1:0] rem_init;

  // The quotient of (dividend << 18) / divisor overflows 31 bits exactly
  // when the dividend's top bits already reach the divisor.
  assign rem_init = dividend_i >> HI_SH;
  assign trial    = {rem_q, dsr_q[QW-1]};
  assign ge       = trial >= {1'b0, dvs_q};

  // Sequencing of the restoring divide, one quotient bit per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == cotd_pkg::DIV_CNT_W'(QW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // Remainder, dividend shifter and quotient.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= rem_init;
      dvs_q <= divisor_i;
      ovf_q <= rem_init >= divisor_i;
      dsr_q <= {dividend_i[HI_SH-1:0], {QF{1'b0}}};
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? IW'(trial - {1'b0, dvs_q}) : trial[IW-1:0];
      dsr_q <= {dsr_q[QW-2:0], 1'b0};
      quo_q <= {quo_q[QW-2:0], ge};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = ovf_q ? cotd_pkg::COT_MAX : quo_q;

endmodule

`default_nettype wire

// ===== hw/rtl/table_cotangent_decimated_unit.sv =====
`default_nettype none

// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_stall_o   frequency_i (24b signed Q15.8)
// out       output     out_valid_o / out_stall_i cotangent_o (31b unsigned Q13.18)
// cfg       input      cfg_we_i                  cfg_wdata_i (freq_scale, Q0.32)
//
// One beat is in flight at a time. A beat with a nonzero phase count is
// accepted while idle and its held value shows on the output the next cycle.
// A beat at phase zero runs the bit-serial multiply, the clamp, the table
// reads and interpolation, then starts and runs the bit-serial divider and
// loads the output (a negative frequency skips the multiply and the clamp).
// Reset clears the phase count, the held value and freq_scale to 2/48000.
// A stalled output beat holds its value and blocks new input beats.
module table_cotangent_decimated_unit #(
  parameter int unsigned TABLE_SIZE = cotd_pkg::TABLE_SIZE_DEF,
  parameter int unsigned DECIMATION = cotd_pkg::DECIMATION_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic signed [cotd_pkg::FREQ_W-1:0]  frequency_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic             [cotd_pkg::COT_W-1:0]   cotangent_o,
  input  wire logic                                cfg_we_i,
  input  wire logic        [cotd_pkg::SCALE_W-1:0] cfg_wdata_i
);

  localparam int ADDR_W  = $clog2(TABLE_SIZE + 1);
  localparam int POS_W   = cotd_pkg::NORM_W + ADDR_W;
  localparam int PHASE_W = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;
  localparam int FW      = cotd_pkg::FREQ_W;
  localparam int SW      = cotd_pkg::SCALE_W;
  localparam int NW      = cotd_pkg::NORM_W;
  localparam int RW      = cotd_pkg::ROM_W;
  localparam int IW      = cotd_pkg::INTERP_W;
  localparam int CW      = cotd_pkg::COT_W;
  localparam int LOW_W   = FW - 1;
  localparam int WIDE_W  = SW + 7;  // product bits 54:16

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_MUL    = 4'd1;
  localparam logic [3:0] ST_CLAMP  = 4'd2;
  localparam logic [3:0] ST_POS    = 4'd3;
  localparam logic [3:0] ST_RD0    = 4'd4;
  localparam logic [3:0] ST_RD1    = 4'd5;
  localparam logic [3:0] ST_LERPC  = 4'd6;
  localparam logic [3:0] ST_LERPS  = 4'd7;
  localparam logic [3:0] ST_DSTART = 4'd8;
  localparam logic [3:0] ST_DWAIT  = 4'd9;
  localparam logic [3:0] ST_OUT    = 4'd10;

  logic [3:0]                       state_q, state_d;
  logic [SW-1:0]                    scale_q;
  logic [PHASE_W-1:0]               phase_q;
  logic [CW-1:0]                    held_q;
  logic                             out_vld_q;
  logic [CW-1:0]                    out_cot_q;
  logic [cotd_pkg::MUL_CNT_W-1:0]   cnt_q;
  logic [LOW_W-1:0]                 mplier_q;
  logic [SW-1:0]                    acc_q;
  logic [LOW_W-1:0]                 lo_q;
  logic [NW-1:0]                    norm_q;
  logic [ADDR_W-1:0]                idx_q;
  logic [cotd_pkg::FRAC_W-1:0]      frac_q;
  logic [RW-1:0]                    cos_lo_q;
  logic [RW-1:0]                    sin_lo_q;
  logic [IW-1:0]                    c_q;
  logic [IW-1:0]                    s_q;

  logic                             out_free;
  logic                             in_acc;
  logic [SW:0]                      mul_sum;
  logic [WIDE_W-1:0]                norm_wide;
  logic [NW-1:0]                    norm_clamp;
  logic [POS_W-1:0]                 pos;
  logic                             rd_en;
  logic [ADDR_W-1:0]                rd_addr;
  logic [RW-1:0]                    rom_cos;
  logic [RW-1:0]                    rom_sin;
  logic [RW-1:0]                    lerp_lo;
  logic [RW-1:0]                    lerp_hi;
  logic [RW-1:0]                    lerp_diff;
  logic [IW-1:0]                    lerp_prod;
  logic [IW-1:0]                    lerp_base;
  logic [IW-1:0]                    lerp_res;
  logic                             div_start;
  cotd_pkg::div_stat_t              div_stat;
  logic [CW-1:0]                    div_quot;

  // Handshake: input is taken only when idle and the output slot frees up.
  assign out_free   = !out_vld_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) && out_free);
  assign in_acc     = in_valid_i && !in_stall_o;

  // Shift-add multiply step, LSB of the frequency magnitude first.
  assign mul_sum = {1'b0, acc_q} + (mplier_q[0] ? {1'b0, scale_q} : {(SW + 1){1'b0}});

  // Normalized frequency and its clamp.
  assign norm_wide = {acc_q, lo_q[LOW_W-1:LOW_W-7]};
  always_comb begin
    if (norm_wide < WIDE_W'(cotd_pkg::NORM_MIN)) begin
      norm_clamp = cotd_pkg::NORM_MIN;
    end else if (norm_wide > WIDE_W'(cotd_pkg::NORM_MAX)) begin
      norm_clamp = cotd_pkg::NORM_MAX;
    end else begin
      norm_clamp = norm_wide[NW-1:0];
    end
  end

  // Table position: integer part indexes the tables, the rest interpolates.
  assign pos = POS_W'(norm_q) * POS_W'(TABLE_SIZE);

  // Table read addresses: lower entry first, then the upper one.
  assign rd_en   = (state_q == ST_RD0) || (state_q == ST_RD1);
  assign rd_addr = (state_q == ST_RD1) ? ADDR_W'(idx_q + 1'b1) : idx_q;

  // Shared interpolation multiplier, cosine then sine.
  always_comb begin
    if (state_q == ST_LERPS) begin
      lerp_lo = sin_lo_q;
      lerp_hi = rom_sin;
    end else begin
      lerp_lo = cos_lo_q;
      lerp_hi = rom_cos;
    end
    lerp_diff = (lerp_hi >= lerp_lo) ? RW'(lerp_hi - lerp_lo) : RW'(lerp_lo - lerp_hi);
    lerp_prod = IW'(lerp_diff) * IW'(frac_q);
    lerp_base = {lerp_lo, {cotd_pkg::FRAC_W{1'b0}}};
    lerp_res  = (lerp_hi >= lerp_lo) ? IW'(lerp_base + lerp_prod)
                                     : IW'(lerp_base - lerp_prod);
  end

  assign div_start = (state_q == ST_DSTART);

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (phase_q == '0)) begin
          state_d = frequency_i[FW-1] ? ST_POS : ST_MUL;
        end
      end
      ST_MUL: begin
        if (cnt_q == cotd_pkg::MUL_CNT_W'(cotd_pkg::MUL_STEPS - 1)) begin
          state_d = ST_CLAMP;
        end
      end
      ST_CLAMP:  state_d = ST_POS;
      ST_POS:    state_d = ST_RD0;
      ST_RD0:    state_d = ST_RD1;
      ST_RD1:    state_d = ST_LERPC;
      ST_LERPC:  state_d = ST_LERPS;
      ST_LERPS:  state_d = ST_DSTART;
      ST_DSTART: state_d = ST_DWAIT;
      ST_DWAIT: begin
        if (div_stat.done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // Control state: sequencer, phase count, held value, output valid, scale.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      phase_q   <= '0;
      held_q    <= '0;
      out_vld_q <= 1'b0;
      scale_q   <= cotd_pkg::FREQ_SCALE_RST;
      cnt_q     <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        scale_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        if (phase_q == PHASE_W'(DECIMATION - 1)) begin
          phase_q <= '0;
        end else begin
          phase_q <= phase_q + 1'b1;
        end
      end
      if (state_q == ST_MUL) begin
        cnt_q <= cnt_q + 1'b1;
      end else begin
        cnt_q <= '0;
      end
      if ((state_q == ST_OUT) && out_free) begin
        held_q <= div_quot;
      end
      if (in_acc && (phase_q != '0)) begin
        out_vld_q <= 1'b1;
      end else if ((state_q == ST_OUT) && out_free) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_acc && (phase_q != '0)) begin
      out_cot_q <= held_q;
    end else if ((state_q == ST_OUT) && out_free) begin
      out_cot_q <= div_quot;
    end
    case (state_q)
      ST_IDLE: begin
        mplier_q <= frequency_i[LOW_W-1:0];
        acc_q    <= '0;
        lo_q     <= '0;
        norm_q   <= cotd_pkg::NORM_MIN;
      end
      ST_MUL: begin
        acc_q    <= mul_sum[SW:1];
        lo_q     <= {mul_sum[0], lo_q[LOW_W-1:1]};
        mplier_q <= {1'b0, mplier_q[LOW_W-1:1]};
      end
      ST_CLAMP: begin
        norm_q <= norm_clamp;
      end
      ST_POS: begin
        if (pos[POS_W-1:NW] >= POS_W'(TABLE_SIZE)) begin
          idx_q  <= ADDR_W'(TABLE_SIZE - 1);
          frac_q <= '1;
        end else begin
          idx_q  <= pos[NW+ADDR_W-1:NW];
          frac_q <= pos[NW-1:0];
        end
      end
      ST_RD1: begin
        cos_lo_q <= rom_cos;
        sin_lo_q <= rom_sin;
      end
      ST_LERPC: begin
        c_q <= lerp_res;
      end
      ST_LERPS: begin
        s_q <= lerp_res;
      end
      default: begin
      end
    endcase
  end

  cotd_rom #(
    .TABLE_SIZE (TABLE_SIZE),
    .ADDR_W     (ADDR_W)
  ) u_rom (
    .clk_i   (clk_i),
    .rd_en_i (rd_en),
    .addr_i  (rd_addr),
    .cos_o   (rom_cos),
    .sin_o   (rom_sin)
  );

  cotd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (c_q),
    .divisor_i  (s_q),
    .stat_o     (div_stat),
    .quot_o     (div_quot)
  );

  assign out_valid_o = out_vld_q;
  assign cotangent_o = out_cot_q;

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  typedef longint unsigned u64_t;
  typedef longint          s64_t;

  // Block configuration used by both the instance and the predictor.
  localparam int unsigned TBL_N        = 512;
  localparam int unsigned DECIM        = 4;
  localparam int unsigned TAYLOR_TERMS = 10;

  localparam u64_t NORM_LO     = 64'd1678;
  localparam u64_t NORM_HI     = 64'd15099494;
  localparam u64_t HALF_PI_Q30 = 64'd1686629713;
  localparam u64_t FRAC_MASK   = 64'hFF_FFFF;
  localparam u64_t COT_SAT     = 64'h7FFF_FFFF;

  // At the low clamp the first table interval gives cos = 65536 and sin = 201,
  // so the cotangent is 2^48 / (201 * 839), floored.
  localparam logic [30:0] COT_FLOOR = 31'd1669097757;

  localparam int unsigned SETTLE_CYCLES  = 80;
  localparam int unsigned DRAIN_CYCLES   = 100;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned RAND_PER_PHASE = 112;
  localparam int unsigned NUM_PHASES     = 8;

  typedef enum int unsigned {
    FLOW_FREE,
    FLOW_SRC_IDLE,
    FLOW_SNK_STALL,
    FLOW_BOTH
  } flow_mode_e;

  typedef struct packed {
    logic signed [23:0] freq;
    logic               known;
    logic [30:0]        cot;
  } freq_row_t;

  // Directed beats. Every fourth beat starts a decimation period and computes
  // a new value; the three after it must return the held value.
  localparam freq_row_t DIRECTED [25] = '{
    '{24'h800000,      1'b1, COT_FLOOR},  // most negative: low clamp
    '{24'sd8388607,    1'b1, COT_FLOOR},
    '{24'sd1,          1'b1, COT_FLOOR},
    '{-24'sd1,         1'b1, COT_FLOOR},
    '{24'sd0,          1'b1, COT_FLOOR},  // zero frequency: low clamp
    '{24'sd614,        1'b1, COT_FLOOR},
    '{-24'sd256,       1'b1, COT_FLOOR},
    '{24'sd6144000,    1'b1, COT_FLOOR},
    '{24'sd8388607,    1'b0, 31'd0},      // largest frequency: high clamp
    '{24'sd0,          1'b0, 31'd0},
    '{24'h800000,      1'b0, 31'd0},
    '{24'sd12345,      1'b0, 31'd0},
    '{24'sd615,        1'b0, 31'd0},      // just above the low clamp
    '{24'sd8388607,    1'b0, 31'd0},
    '{-24'sd77,        1'b0, 31'd0},
    '{24'sd1,          1'b0, 31'd0},
    '{24'sd25600,      1'b0, 31'd0},      // 100 Hz
    '{24'sd99,         1'b0, 31'd0},
    '{24'sd4000000,    1'b0, 31'd0},
    '{-24'sd4000000,   1'b0, 31'd0},
    '{24'sd3072000,    1'b0, 31'd0},      // quarter of the rate, cot near one
    '{24'sd3,          1'b0, 31'd0},
    '{24'sd7000000,    1'b0, 31'd0},
    '{24'sd500,        1'b0, 31'd0},
    '{24'sd5529600,    1'b0, 31'd0}       // right at the high clamp
  };

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  logic signed [23:0] frequency_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [30:0]       cotangent_o;
  logic              cfg_we_i    = 1'b0;
  logic [31:0]       cfg_wdata_i = '0;

  // Predictor state: tables, register copy, decimation phase and held value.
  u64_t        cos_q16 [0:TBL_N];
  u64_t        sin_q16 [0:TBL_N];
  logic [31:0] scale_reg = 32'd178957;
  int unsigned phase_ctr = 0;
  logic [30:0] held_cot  = '0;

  logic [30:0] cot_expected [$];
  int unsigned mismatch_cnt   = 0;
  int unsigned idle_cycles    = 0;
  int unsigned src_idle_pct   = 0;
  int unsigned snk_stall_pct  = 0;

  table_cotangent_decimated_unit #(
    .TABLE_SIZE(TBL_N),
    .DECIMATION(DECIM)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .frequency_i(frequency_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cotangent_o(cotangent_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // Free-running clock, 8 ns period.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Round a Q2.30 series sum to a Q1.16 table entry, clamped to 0 .. 1.0.
  function automatic u64_t q30_round_q16(s64_t acc);
    u64_t v;
    if (acc < 0) acc = 0;
    v = (u64_t'(acc) + 64'd8192) >> 14;
    if (v > 64'd65536) v = 64'd65536;
    return v;
  endfunction

  // Quarter-wave tables from truncated Taylor series in Q2.30.
  function automatic void build_quarter_wave();
    u64_t ang, ang2, sin_term, cos_term;
    s64_t sin_acc, cos_acc;
    for (int i = 0; i <= TBL_N; i++) begin
      ang      = (u64_t'(i) * HALF_PI_Q30) / u64_t'(TBL_N);
      ang2     = (ang * ang) >> 30;
      sin_term = ang;
      cos_term = 64'd1 << 30;
      sin_acc  = s64_t'(sin_term);
      cos_acc  = s64_t'(cos_term);
      for (int k = 1; k <= TAYLOR_TERMS; k++) begin
        sin_term = ((sin_term * ang2) >> 30) / u64_t'((2 * k) * (2 * k + 1));
        cos_term = ((cos_term * ang2) >> 30) / u64_t'((2 * k - 1) * (2 * k));
        if (k % 2 == 1) begin
          sin_acc -= s64_t'(sin_term);
          cos_acc -= s64_t'(cos_term);
        end else begin
          sin_acc += s64_t'(sin_term);
          cos_acc += s64_t'(cos_term);
        end
      end
      sin_q16[i] = q30_round_q16(sin_acc);
      cos_q16[i] = q30_round_q16(cos_acc);
    end
  endfunction

  // Exact Q1.40 interpolation between two Q1.16 entries.
  function automatic u64_t interp_q40(u64_t lo, u64_t hi, u64_t frac);
    if (hi >= lo) return (lo << 24) + (hi - lo) * frac;
    return (lo << 24) - (lo - hi) * frac;
  endfunction

  function automatic logic [30:0] cot_of(logic [23:0] freq_bits, logic [31:0] scale);
    u64_t norm, pos, idx, frac, c, s, q;
    if (freq_bits[23]) begin
      norm = NORM_LO;
    end else begin
      norm = (u64_t'(freq_bits) * u64_t'(scale)) >> 16;
      if (norm < NORM_LO) norm = NORM_LO;
      else if (norm > NORM_HI) norm = NORM_HI;
    end
    pos  = norm * u64_t'(TBL_N);
    idx  = pos >> 24;
    frac = pos & FRAC_MASK;
    // The clamp keeps the index inside the table; pin it anyway.
    if (idx >= u64_t'(TBL_N)) begin
      idx  = u64_t'(TBL_N) - 1;
      frac = FRAC_MASK;
    end
    c = interp_q40(cos_q16[idx], cos_q16[idx + 1], frac);
    s = interp_q40(sin_q16[idx], sin_q16[idx + 1], frac);
    if (s == 0) return COT_SAT[30:0];
    q = (c << 18) / s;
    if (q > COT_SAT) q = COT_SAT;
    return q[30:0];
  endfunction

  // One accepted input beat: recompute at phase zero, then return the held value.
  function automatic logic [30:0] advance_decimator(logic [23:0] freq_bits);
    if (phase_ctr == 0) held_cot = cot_of(freq_bits, scale_reg);
    phase_ctr = (phase_ctr + 1 >= DECIM) ? 0 : phase_ctr + 1;
    return held_cot;
  endfunction

  // Random frequency, mostly inside the unclamped band of the current scale.
  function automatic logic [23:0] pick_freq(logic [31:0] scale);
    u64_t        span;
    logic [23:0] bits;
    span = ((NORM_HI + 1) << 16) / u64_t'((scale == 32'd0) ? 32'd1 : scale);
    if (span > 64'h7F_FFFF) span = 64'h7F_FFFF;
    case ($urandom_range(7))
      0, 1: bits = 24'($urandom());
      6: bits = 24'($urandom_range(32'(span >> 12) + 32'd2));
      7: bits = -24'($urandom_range(4096));
      default: bits = 24'($urandom_range(32'(span)));
    endcase
    return bits;
  endfunction

  task automatic report_mismatch(input string what, input logic [30:0] want,
                                 input logic [30:0] got);
    $display("%0t ns: cotangent %s: expected %0d, got %0d", $time, what, want, got);
    mismatch_cnt++;
  endtask

  // Drive one input beat, with a random lead-in gap, and log its expectation.
  task automatic send_freq(input logic signed [23:0] freq, input logic known,
                           input logic [30:0] typed_cot);
    logic [30:0] predicted;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    frequency_i <= freq;
    do @(posedge clk_i); while (in_stall_o);
    predicted = advance_decimator(freq);
    cot_expected.push_back(known ? typed_cot : predicted);
    @(negedge clk_i);
  endtask

  // Register writes happen only once every result is out and the block is quiet.
  task automatic write_freq_scale(input logic [31:0] value);
    while (cot_expected.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i  <= 1'b0;
    scale_reg = value;
  endtask

  // Receiver back-pressure.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < snk_stall_pct);
  end

  // Compare each output beat against the oldest expectation.
  always @(posedge clk_i) begin : out_check
    logic [30:0] want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (cot_expected.size() == 0) begin
        report_mismatch("beat with nothing pending", 'x, cotangent_o);
      end else begin
        want = cot_expected.pop_front();
        if (cotangent_o !== want) report_mismatch("mismatch", want, cotangent_o);
      end
    end
  end

  // Watchdog on cycles without any beat on either channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [31:0] scale_plan [NUM_PHASES];
    flow_mode_e  mode;
    build_quarter_wave();
    scale_plan = '{32'd178957, 32'd0, 32'd1, 32'hFFFF_FFFF,
                   32'd97391, 32'd536871, $urandom(), 32'd1789570};

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table at the reset value of the scale, no idling.
    for (int r = 0; r < $size(DIRECTED); r++) begin
      send_freq(DIRECTED[r].freq, DIRECTED[r].known, DIRECTED[r].cot);
    end

    // Random phases, each with its own scale and flow-control mix.
    for (int p = 0; p < NUM_PHASES; p++) begin
      in_valid_i <= 1'b0;
      write_freq_scale(scale_plan[p]);
      mode = flow_mode_e'(p % 4);
      case (mode)
        FLOW_FREE: begin
          src_idle_pct  = 0;
          snk_stall_pct = 0;
        end
        FLOW_SRC_IDLE: begin
          src_idle_pct  = 74;
          snk_stall_pct = 0;
        end
        FLOW_SNK_STALL: begin
          src_idle_pct  = 0;
          snk_stall_pct = 74;
        end
        default: begin
          src_idle_pct  = 11;
          snk_stall_pct = 11;
        end
      endcase
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        send_freq(pick_freq(scale_reg), 1'b0, 31'd0);
      end
    end

    in_valid_i <= 1'b0;
    while (cot_expected.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/cotd_pkg.sv
hw/rtl/cotd_rom.sv
hw/rtl/cotd_div.sv
hw/rtl/table_cotangent_decimated_unit.sv
bench/tb_top.sv
